>>> hw/rtl/sliding_window_peak_rate_assert.svh
// assertion macros for the sliding window peak rate block
`ifndef SLIDING_WINDOW_PEAK_RATE_ASSERT_SVH
`define SLIDING_WINDOW_PEAK_RATE_ASSERT_SVH

`ifndef SYNTHESIS

// plain property check on every clock edge outside reset
`define SWPR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SWPR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SWPR_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SWPR_ASSERT(name, clk, rst, prop, msg)
`define SWPR_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define SWPR_ASSERT_NXT(name, clk, rst, ante, cons, msg)

`endif

`endif

>>> hw/rtl/swpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swpr_pkg;

   localparam int TIME_W     = 31;
   localparam int COUNT_W    = 11;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_FROM    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_TO      = 2'd2;

   localparam logic [TIME_W-1:0] RANGE_TO_RESET = {TIME_W{1'b1}};

   typedef logic [TIME_W-1:0] time_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // one ring operation per cycle at most
   typedef struct packed {
      logic retire;
      logic append;
   } ring_cmd_type;

   typedef struct packed {
      logic     empty;
      logic     full;
      time_type head_data;
   } ring_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/swpr_ring.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_window_peak_rate_assert.svh"

module swpr_ring #(
   parameter int RING_DEPTH = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire swpr_pkg::ring_cmd_type            cmd,
   input  wire swpr_pkg::time_type                wdata,
   output swpr_pkg::ring_status_type              status,
   output logic [$clog2(RING_DEPTH+1)-1:0]        live_count
);
   import swpr_pkg::*;

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

   time_type time_ring_mem [RING_DEPTH];

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] live_ff, live_in;
   time_type         rd_data_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      live_in = live_ff;
      if (cmd.retire) begin
         head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
         live_in = live_ff - 1'b1;
      end else if (cmd.append) begin
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
         live_in = live_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         live_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         live_ff <= live_in;
      end
   end

   // read the upcoming head every cycle, data lands in the following cycle
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         time_ring_mem[tail_ff] <= wdata;
      end
      rd_data_ff <= time_ring_mem[head_in];
   end

   assign status.empty     = (live_ff == '0);
   assign status.full      = (live_ff == CNT_FULL);
   assign status.head_data = rd_data_ff;
   assign live_count       = live_ff;

   `SWPR_ASSERT(a_live_bound, clock, reset, live_ff <= CNT_FULL,
      "ring live count above depth")
   `SWPR_ASSERT_IMP(a_no_retire_empty, clock, reset, cmd.retire, live_ff != '0,
      "retire on empty ring")
   `SWPR_ASSERT_IMP(a_no_append_full, clock, reset, cmd.append, live_ff != CNT_FULL,
      "append on full ring")

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_peak_rate.sv
// sequence: accept in idle, then scan, retiring one expired entry per cycle, then finish when
//   the output register is free; the result is registered and valid the cycle after finish
// pace: requests stall outside idle; the single ring read port limits retires to one per cycle
// reset: synchronous, active high; clears pointers, counts, peak and config registers
//   (window 0, range 0 .. max); ring memory is not cleared, entries are only read once written
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_window_peak_rate_assert.svh"

module sliding_window_peak_rate #(
   parameter int RING_DEPTH = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_write,
   input  wire logic [swpr_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  wire logic [swpr_pkg::TIME_W-1:0]         csr_wdata,
   // event transactions
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [swpr_pkg::TIME_W-1:0]         req_event_time,
   // result transactions
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_accepted,
   output logic [swpr_pkg::COUNT_W-1:0]             rsp_window_count,
   output logic [swpr_pkg::COUNT_W-1:0]             rsp_peak_count,
   output logic [swpr_pkg::TIME_W-1:0]              rsp_peak_start,
   output logic                                     rsp_overflow
);
   import swpr_pkg::*;

   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   // configuration registers
   time_type window_length_ff, range_from_ff, range_to_ff;

   // control
   state_type state_ff, state_in;
   time_type  time_ff;      // timestamp of the transaction in flight
   logic      active_ff;    // counting enabled and in range

   // peak tracking
   logic [CNT_W-1:0] best_count_ff, best_count_in;
   time_type         best_start_ff, best_start_in;

   // output stage
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_accepted_ff;
   logic [COUNT_W-1:0]  rsp_window_count_ff;
   logic [COUNT_W-1:0]  rsp_peak_count_ff;
   time_type            rsp_peak_start_ff;
   logic                rsp_overflow_ff;

   ring_cmd_type     ring_cmd;
   ring_status_type  ring_status;
   logic [CNT_W-1:0] live_count;
   logic [CNT_W-1:0] live_after;

   logic              req_take;
   logic              in_range;
   logic [TIME_W:0]   age;
   logic              age_expired;
   logic              out_free;
   logic              finish;

   swpr_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ring_cmd),
      .wdata      (time_ff),
      .status     (ring_status),
      .live_count (live_count)
   );

   // config port, unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= '0;
         range_from_ff    <= '0;
         range_to_ff      <= RANGE_TO_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata;
            CSR_RANGE_FROM:    range_from_ff    <= csr_wdata;
            CSR_RANGE_TO:      range_to_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign in_range  = (window_length_ff != '0) && (req_event_time >= range_from_ff)
                      && (req_event_time <= range_to_ff);

   // signed age of the head entry, negative never expires
   assign age         = {1'b0, time_ff} - {1'b0, ring_status.head_data};
   assign age_expired = !age[TIME_W] && (age[TIME_W-1:0] >= window_length_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ring_cmd      = '0;
      finish        = 1'b0;
      state_in      = state_ff;
      best_count_in = best_count_ff;
      best_start_in = best_start_ff;
      live_after    = live_count;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (active_ff && !ring_status.empty && age_expired) begin
               // drop one expired entry per cycle
               ring_cmd.retire = 1'b1;
            end else if (out_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
               if (active_ff && !ring_status.full) begin
                  ring_cmd.append = 1'b1;
                  live_after      = live_count + 1'b1;
                  if (live_after > best_count_ff) begin
                     best_count_in = live_after;
                     // an empty ring means the new entry is the window start
                     best_start_in = ring_status.empty ? time_ff : ring_status.head_data;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         best_count_ff <= '0;
         best_start_ff <= '0;
      end else begin
         state_ff      <= state_in;
         best_count_ff <= best_count_in;
         best_start_ff <= best_start_in;
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         time_ff   <= req_event_time;
         active_ff <= in_range;
      end
   end

   // output register, refilled only when free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_accepted_ff     <= active_ff;
         rsp_window_count_ff <= COUNT_W'(live_after);
         rsp_peak_count_ff   <= COUNT_W'(best_count_in);
         rsp_peak_start_ff   <= best_start_in;
         rsp_overflow_ff     <= active_ff && ring_status.full;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_window_count = rsp_window_count_ff;
   assign rsp_peak_count   = rsp_peak_count_ff;
   assign rsp_peak_start   = rsp_peak_start_ff;
   assign rsp_overflow     = rsp_overflow_ff;

   `SWPR_ASSERT_IMP(a_overflow_needs_accept, clock, reset, rsp_valid_ff && rsp_overflow_ff,
      rsp_accepted_ff, "overflow reported on an item that was not counted")
   `SWPR_ASSERT(a_peak_covers_live, clock, reset, best_count_ff >= live_count,
      "peak count below live window count")
   `SWPR_ASSERT_NXT(a_take_starts_scan, clock, reset, req_take, state_ff == ST_SCAN,
      "accepted transaction did not start a scan")

endmodule

`default_nettype wire
